/* rtl/playfair_digraph_stream_defines.svh */
// Assertion macros shared by the Playfair digraph stream RTL.
`ifndef PLAYFAIR_DIGRAPH_STREAM_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_STREAM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PFDS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFDS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pfds_pkg.sv */
`timescale 1ns / 1ps

package pfds_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam int ROWS       = 5;
    localparam int CELLS      = 25;
    localparam int KEY_CELLS  = 5;
    localparam int FILL_CELLS = 20;

    typedef logic [4:0] cell_t;
    typedef logic [2:0] pos_t;

    // ASCII
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;
    localparam logic [7:0] CH_LOWER_A  = 8'd97;
    localparam logic [7:0] CH_LOWER_Z  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] CH_PAD      = 8'd88;   // 'X'

    // letter codes, A = 0
    localparam cell_t CODE_I    = 5'd8;
    localparam cell_t CODE_J    = 5'd9;
    localparam cell_t CODE_PAD  = 5'd23;
    localparam cell_t CODE_LAST = 5'd25;

    typedef enum logic [2:0] {
        REG_KEY_A     = 3'd0,
        REG_KEY_B     = 3'd1,
        REG_KEY_C     = 3'd2,
        REG_KEY_D     = 3'd3,
        REG_KEY_E     = 3'd4,
        REG_DIRECTION = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RB_CLR,
        ST_RB_SCAN,
        ST_LOCATE,
        ST_PLACE,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_FL_READ,
        ST_FL_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic rb_clear;
        logic rb_step;
        logic locate;
        logic place;
        logic look_a;
        logic look_b;
        logic fl_read;
        logic fl_emit;
    } cmd_t;

    typedef struct packed {
        logic key_wr;
        logic item_pair;
        logic item_flush;
        logic rb_done;
        logic out_free;
        logic fl_last;
    } stat_t;

    // table for the reset key A..E: key row, then F..Z without J
    function automatic cell_t default_cell(input int k);
        cell_t c;
        if (k < 9)
            c = cell_t'(k);
        else
            c = cell_t'(k + 1);
        return c;
    endfunction

    // one step around a row or column, forward when fwd is set
    function automatic pos_t step_mod5(input pos_t v, input logic fwd);
        pos_t r;
        if (fwd)
            r = (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
        else
            r = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
        return r;
    endfunction

endpackage

/* rtl/pfds_ctrl.sv */
`timescale 1ns / 1ps

`include "playfair_digraph_stream_defines.svh"

module pfds_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pfds_pkg::stat_t  stat,
    output pfds_pkg::cmd_t   cmd
);

    pfds_pkg::state_t state_reg;
    pfds_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (stat.key_wr)
        begin
            state_next = pfds_pkg::ST_RB_CLR;   // any key write restarts the rebuild
        end
        else
        begin
            case (state_reg)
                pfds_pkg::ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (stat.item_pair)
                            state_next = pfds_pkg::ST_LOCATE;
                        else if (stat.item_flush)
                            state_next = pfds_pkg::ST_FL_READ;
                    end
                end
                pfds_pkg::ST_RB_CLR:  state_next = pfds_pkg::ST_RB_SCAN;
                pfds_pkg::ST_RB_SCAN:
                begin
                    if (stat.rb_done)
                        state_next = pfds_pkg::ST_IDLE;
                end
                pfds_pkg::ST_LOCATE:  state_next = pfds_pkg::ST_PLACE;
                pfds_pkg::ST_PLACE:   state_next = pfds_pkg::ST_LOOK_A;
                pfds_pkg::ST_LOOK_A:  state_next = pfds_pkg::ST_LOOK_B;
                pfds_pkg::ST_LOOK_B:  state_next = pfds_pkg::ST_FL_READ;
                pfds_pkg::ST_FL_READ: state_next = pfds_pkg::ST_FL_EMIT;
                pfds_pkg::ST_FL_EMIT:
                begin
                    if (stat.out_free)
                        state_next = stat.fl_last ? pfds_pkg::ST_IDLE : pfds_pkg::ST_FL_READ;
                end
                default: state_next = pfds_pkg::ST_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            pfds_pkg::ST_IDLE:
            begin
                s_tready = !stat.key_wr;
                cmd.take = s_tvalid && !stat.key_wr;
            end
            pfds_pkg::ST_RB_CLR:  cmd.rb_clear = 1'b1;
            pfds_pkg::ST_RB_SCAN: cmd.rb_step  = 1'b1;
            pfds_pkg::ST_LOCATE:  cmd.locate   = 1'b1;
            pfds_pkg::ST_PLACE:   cmd.place    = 1'b1;
            pfds_pkg::ST_LOOK_A:  cmd.look_a   = 1'b1;
            pfds_pkg::ST_LOOK_B:  cmd.look_b   = 1'b1;
            pfds_pkg::ST_FL_READ: cmd.fl_read  = 1'b1;
            pfds_pkg::ST_FL_EMIT: cmd.fl_emit  = 1'b1;
            default:              cmd          = '0;
        endcase
    end

    `PFDS_ASSERT_NEXT(a_pair_goes_to_locate, clk, rst_n, cmd.take && stat.item_pair, state_reg == pfds_pkg::ST_LOCATE, "completed pair did not start the lookup")
    `PFDS_ASSERT_NEXT(a_rebuild_returns_idle, clk, rst_n, state_reg == pfds_pkg::ST_RB_SCAN && stat.rb_done && !stat.key_wr, state_reg == pfds_pkg::ST_IDLE, "table rebuild did not finish")

endmodule

/* rtl/pfds_datapath.sv */
`timescale 1ns / 1ps

`include "playfair_digraph_stream_defines.svh"

module pfds_datapath
#(
    parameter int BUFFER_DEPTH = pfds_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pfds_pkg::cmd_t   cmd,
    output pfds_pkg::stat_t  stat,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // letter table and config
    pfds_pkg::cell_t table_reg [pfds_pkg::CELLS];
    logic            direction_reg;
    logic [4:0]      rb_ptr_reg;
    pfds_pkg::cell_t rb_code_reg;

    // held run
    logic [7:0]      store_mem [BUFFER_DEPTH];
    logic [7:0]      mem_q_reg;
    logic [CW-1:0]   count_reg;
    logic            held_reg;
    logic [AW-1:0]   first_slot_reg;
    pfds_pkg::cell_t first_code_reg;
    pfds_pkg::cell_t second_code_reg;
    logic            pair_reg;
    logic            overflow_reg;
    logic [AW-1:0]   rd_ptr_reg;

    // pair lookup
    logic            found_reg;
    pfds_pkg::pos_t  row_a_reg, col_a_reg, row_b_reg, col_b_reg;
    pfds_pkg::cell_t idx_a_reg, idx_b_reg;
    pfds_pkg::cell_t sub_a_reg, sub_b_reg;
    logic            subst_reg;

    // output stage
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            out_user_reg;

    // ---------------- input decode ----------------
    logic [7:0]      cap_byte;
    logic            is_letter;
    pfds_pkg::cell_t in_code;
    logic            room;
    logic            wr_en;
    logic [7:0]      wr_data;
    logic            key_wr;

    always_comb
    begin
        if (s_tdata >= pfds_pkg::CH_LOWER_A && s_tdata <= pfds_pkg::CH_LOWER_Z)
            cap_byte = s_tdata - pfds_pkg::CASE_OFFSET;
        else
            cap_byte = s_tdata;
        is_letter = (cap_byte >= pfds_pkg::CH_UPPER_A) && (cap_byte <= pfds_pkg::CH_UPPER_Z);
        in_code   = 5'(cap_byte - pfds_pkg::CH_UPPER_A);
        // keep room for the letters still missing from the pair
        room = ((CW+1)'(count_reg) + (CW+1)'(2) - (CW+1)'(held_reg))
               < (CW+1)'(BUFFER_DEPTH);
        wr_en   = cmd.take && (s_tlast ? held_reg : (is_letter || room));
        wr_data = s_tlast ? pfds_pkg::CH_PAD : cap_byte;
    end

    assign key_wr = cfg_valid && (cfg_index <= pfds_pkg::REG_KEY_E);

    // ---------------- table: key row, rebuild sweep ----------------
    logic            rb_eligible;

    always_comb
    begin
        rb_eligible = (rb_code_reg != pfds_pkg::CODE_J);
        for (int i = 0; i < pfds_pkg::KEY_CELLS; i++)
        begin
            if (table_reg[i] == rb_code_reg)
                rb_eligible = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pfds_pkg::CELLS; k++)
                table_reg[k] <= pfds_pkg::default_cell(k);
            direction_reg <= 1'b1;
            rb_ptr_reg    <= '0;
            rb_code_reg   <= '0;
        end
        else
        begin
            if (key_wr)
                table_reg[{2'b00, cfg_index}] <= 5'(cfg_data[4:0] - 5'd1);
            if (cfg_valid && cfg_index == pfds_pkg::REG_DIRECTION)
                direction_reg <= cfg_data[0];
            if (cmd.rb_clear)
            begin
                for (int k = pfds_pkg::KEY_CELLS; k < pfds_pkg::CELLS; k++)
                    table_reg[k] <= pfds_pkg::CODE_LAST;
                rb_ptr_reg  <= '0;
                rb_code_reg <= '0;
            end
            if (cmd.rb_step)
            begin
                if (rb_eligible && rb_ptr_reg < 5'(pfds_pkg::FILL_CELLS))
                begin
                    table_reg[5'(pfds_pkg::KEY_CELLS) + rb_ptr_reg] <= rb_code_reg;
                    rb_ptr_reg <= rb_ptr_reg + 5'd1;
                end
                rb_code_reg <= rb_code_reg + 5'd1;
            end
        end
    end

    // ---------------- store memory ----------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[count_reg[AW-1:0]] <= wr_data;
        if (cmd.fl_read)
            mem_q_reg <= store_mem[rd_ptr_reg];
    end

    // ---------------- locate and place ----------------
    logic            fa, fb;
    pfds_pkg::pos_t  ra, ca, rb, cb;
    pfds_pkg::pos_t  nra, nca, nrb, ncb;
    pfds_pkg::cell_t look_idx;
    pfds_pkg::cell_t look_cell;

    always_comb
    begin
        fa = 1'b0; ra = '0; ca = '0;
        fb = 1'b0; rb = '0; cb = '0;
        // scan from the end so the first match in row-major order wins
        for (int r = pfds_pkg::ROWS - 1; r >= 0; r--)
        begin
            for (int c = pfds_pkg::ROWS - 1; c >= 0; c--)
            begin
                if (table_reg[r*pfds_pkg::ROWS + c] == first_code_reg ||
                    (first_code_reg == pfds_pkg::CODE_J &&
                     table_reg[r*pfds_pkg::ROWS + c] == pfds_pkg::CODE_I))
                begin
                    fa = 1'b1; ra = 3'(r); ca = 3'(c);
                end
                if (table_reg[r*pfds_pkg::ROWS + c] == second_code_reg ||
                    (second_code_reg == pfds_pkg::CODE_J &&
                     table_reg[r*pfds_pkg::ROWS + c] == pfds_pkg::CODE_I))
                begin
                    fb = 1'b1; rb = 3'(r); cb = 3'(c);
                end
            end
        end
    end

    always_comb
    begin
        nra = row_a_reg; nca = col_a_reg;
        nrb = row_b_reg; ncb = col_b_reg;
        if (row_a_reg == row_b_reg)
        begin
            nca = pfds_pkg::step_mod5(col_a_reg, direction_reg);
            ncb = pfds_pkg::step_mod5(col_b_reg, direction_reg);
        end
        else if (col_a_reg == col_b_reg)
        begin
            nra = pfds_pkg::step_mod5(row_a_reg, direction_reg);
            nrb = pfds_pkg::step_mod5(row_b_reg, direction_reg);
        end
        else
        begin
            nca = col_b_reg;
            ncb = col_a_reg;
        end
        look_idx  = cmd.look_b ? idx_b_reg : idx_a_reg;
        look_cell = table_reg[look_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.locate)
        begin
            row_a_reg <= ra; col_a_reg <= ca;
            row_b_reg <= rb; col_b_reg <= cb;
        end
        if (cmd.place)
        begin
            idx_a_reg <= {nra, 2'b00} + {2'b00, nra} + {2'b00, nca};
            idx_b_reg <= {nrb, 2'b00} + {2'b00, nrb} + {2'b00, ncb};
        end
        if (cmd.look_a)
            sub_a_reg <= look_cell;
        if (cmd.look_b)
            sub_b_reg <= look_cell;
    end

    // ---------------- run control ----------------
    logic            emit;
    logic            fl_last;
    logic [7:0]      emit_byte;

    assign stat.out_free = !out_valid_reg || m_tready;
    assign fl_last       = (CW'(rd_ptr_reg) + CW'(1)) == count_reg;
    assign emit          = cmd.fl_emit && stat.out_free;

    always_comb
    begin
        if (subst_reg && rd_ptr_reg == first_slot_reg)
            emit_byte = pfds_pkg::CH_UPPER_A + {3'b000, sub_a_reg};
        else if (subst_reg && fl_last)
            emit_byte = pfds_pkg::CH_UPPER_A + {3'b000, sub_b_reg};
        else
            emit_byte = mem_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            held_reg        <= 1'b0;
            first_slot_reg  <= '0;
            first_code_reg  <= '0;
            second_code_reg <= '0;
            pair_reg        <= 1'b0;
            overflow_reg    <= 1'b0;
            rd_ptr_reg      <= '0;
            found_reg       <= 1'b0;
            subst_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                subst_reg  <= 1'b0;
                rd_ptr_reg <= '0;
                if (s_tlast)
                begin
                    pair_reg <= held_reg;
                    if (held_reg)
                    begin
                        count_reg       <= count_reg + CW'(1);
                        second_code_reg <= pfds_pkg::CODE_PAD;
                    end
                end
                else if (is_letter)
                begin
                    count_reg <= count_reg + CW'(1);
                    if (!held_reg)
                    begin
                        held_reg       <= 1'b1;
                        first_slot_reg <= count_reg[AW-1:0];
                        first_code_reg <= in_code;
                    end
                    else
                    begin
                        second_code_reg <= in_code;
                        pair_reg        <= 1'b1;
                    end
                end
                else if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.locate)
                found_reg <= fa && fb;
            if (cmd.place)
                subst_reg <= pair_reg && found_reg;
            if (emit)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
                if (fl_last)
                begin
                    count_reg      <= '0;
                    held_reg       <= 1'b0;
                    first_slot_reg <= '0;
                    pair_reg       <= 1'b0;
                    subst_reg      <= 1'b0;
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= fl_last;
            out_user_reg <= overflow_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign stat.key_wr     = key_wr;
    assign stat.item_pair  = held_reg && (s_tlast || is_letter);
    assign stat.item_flush = s_tlast && !held_reg && (count_reg != '0);
    assign stat.rb_done    = (rb_code_reg == pfds_pkg::CODE_LAST);
    assign stat.fl_last    = fl_last;

    `PFDS_ASSERT_IMPL(a_held_leaves_room, clk, rst_n, held_reg && !pair_reg, count_reg < CW'(BUFFER_DEPTH), "letter held with no room left for its partner")
    `PFDS_ASSERT_NEXT(a_flush_clears_run, clk, rst_n, emit && fl_last, count_reg == '0 && !held_reg, "run not cleared after its last item")

endmodule

/* rtl/playfair_digraph_stream.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+----------------------------------------
// s_       | in  | s_tvalid / s_tready  | s_tdata = in_byte, s_tlast = end_of_input
// m_       | out | m_tvalid / m_tready  | m_tdata = out_byte, m_tlast = run_last,
//          |     |                      | m_tuser = overflow (sticky)
// cfg_     | in  | cfg_valid / cfg_ready| cfg_index = register, cfg_data = value
//
// An item that holds back (non-letter, first letter) is taken without leaving idle.
// Completing a pair runs the table lookup (locate, place, two table reads),
// then a store read and an output load for each byte of the run.
// Key writes rebuild rows 1..4 of the table; s_tready is low
// meanwhile. cfg_ready is always high.
// Reset loads the table for key ABCDE directly; no clearing pass. A stalled
// m_tready holds the current item and freezes the flush.

module playfair_digraph_stream
#(
    parameter int BUFFER_DEPTH = pfds_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // end of text: pad lone letter, flush

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast,     // last item of the run
    output logic       m_tuser,     // [0] overflow

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);

    pfds_pkg::cmd_t  cmd;
    pfds_pkg::stat_t stat;

    // config writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: item intake, table rebuild, pair lookup, run flush
    pfds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, run store, lookup pipeline and output register
    pfds_datapath
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
